FILE: rtl/hfu_pkg.sv
// ----------------------------------------------------------------------------
// hfu_pkg: shared types, constants and a function of the Huffman font unpacker
// Holds the table store geometry, the command codes, the controller state
// encoding, the command/status structs and the symbol expansion function.
// ----------------------------------------------------------------------------
package hfu_pkg;

  // Table store geometry.
  localparam int TABLE_DEPTH = 512;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // Field widths of the stream items.
  localparam int CMD_W    = 2;
  localparam int TADDR_W  = 9;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 16;
  localparam int NODE_W   = 7;
  localparam int BITIDX_W = 3;

  // Walk restarts at this tree node.
  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(2);

  // Input item kinds, carried on the tuser bits.
  typedef enum logic [CMD_W-1:0] {
    CMD_TABLE = 2'd0,
    CMD_START = 2'd1,
    CMD_BITS  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_SYM  = 4'b1000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tbl_wr;     // write the item's byte into the table store
    logic start;      // load the word counter and restart the walk
    logic load_byte;  // capture a bitstream byte, bit index to zero
    logic tree_rd;    // read the tree entry at node + current bit
    logic step_node;  // the tree entry read is an inner node: follow it
    logic sym_rd;     // read the symbol of the leaf just found
    logic emit;       // load the output register with the expanded symbol
    logic next_bit;   // advance to the next bit of the byte
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic words_zero; // no words left to produce
    logic is_node;    // tree entry read is positive
    logic bit_last;   // current bit is the last bit of the byte
    logic out_free;   // output register can take a word this cycle
    logic last_emit;  // the next word emitted is the final one
  } sts_t;

  // Each 2-bit pair becomes two pixel nibbles; first pair in the lowest byte.
  function automatic logic [WORD_W-1:0] expand_symbol(input logic [BYTE_W-1:0] sym);
    logic [WORD_W-1:0] word;
    word = '0;
    for (int k = 0; k < 4; k++) begin
      word[8*k +: 8] = {3'b000, sym[2*k+1], 3'b000, sym[2*k]};
    end
    return word;
  endfunction

endpackage

FILE: rtl/hfu_ram.sv
// ----------------------------------------------------------------------------
// hfu_ram: generic single-write, single-read RAM with registered read data
// Read data holds its value while the read enable is low.
// ----------------------------------------------------------------------------
module hfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/hfu_ctrl.sv
// ----------------------------------------------------------------------------
// hfu_ctrl: controller of the Huffman font unpacker
// Sequences the per-bit tree walk: one tree read per bit, a symbol read on
// a leaf, and a wait for the output register before each word is emitted.
// ----------------------------------------------------------------------------
module hfu_ctrl
  import hfu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  cmd_code_t in_cmd,
  output logic      in_ready,
  input  sts_t      sts,
  output ctl_t      ctl
);

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_TABLE: ctl.tbl_wr = 1'b1;
            CMD_START: ctl.start  = 1'b1;
            CMD_BITS: begin
              if (!sts.words_zero) begin
                ctl.load_byte = 1'b1;
                state_nxt     = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        ctl.tree_rd = 1'b1;
        state_nxt   = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.is_node) begin
          ctl.step_node = 1'b1;
          if (sts.bit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            ctl.next_bit = 1'b1;
            state_nxt    = ST_READ;
          end
        end else begin
          ctl.sym_rd = 1'b1;
          state_nxt  = ST_SYM;
        end
      end
      ST_SYM: begin
        if (sts.out_free) begin
          ctl.emit = 1'b1;
          if (sts.last_emit || sts.bit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            ctl.next_bit = 1'b1;
            state_nxt    = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A symbol that waits for the output register keeps the controller waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SYM && !sts.out_free) |=> (state_r == ST_SYM))
    else $error("symbol state left before its word was emitted");

  // A tree read is always followed by its evaluation.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.tree_rd |=> (state_r == ST_EVAL))
    else $error("tree read not followed by evaluation");

  // The state register always holds exactly one active state bit.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state is not one-hot");

endmodule

FILE: rtl/hfu_datapath.sv
// ----------------------------------------------------------------------------
// hfu_datapath: datapath of the Huffman font unpacker
// Table store, offset shadow, walk node, bit pointer, word counter and the
// output register, all driven by the controller's commands.
// ----------------------------------------------------------------------------
module hfu_datapath
  import hfu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               ctl,
  output sts_t               sts,
  input  logic [TADDR_W-1:0] in_addr,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WORD_W-1:0]  out_word,
  output logic               out_last
);

  logic [COUNT_W-1:0]  word_count_r, words_left_r;
  logic [BYTE_W-1:0]   offset_r, byte_r;
  logic [NODE_W-1:0]   node_r;
  logic [BITIDX_W-1:0] bit_r;
  logic [WORD_W-1:0]   out_word_r;
  logic                out_last_r, out_valid_r;

  logic                tbl_we, cur_bit;
  logic [ADDR_W-1:0]   tbl_waddr, tbl_raddr;
  logic [BYTE_W-1:0]   raw, mag;

  // Table store.
  assign tbl_waddr = ADDR_W'(in_addr);
  assign tbl_we    = ctl.tbl_wr && (32'(in_addr) < TABLE_DEPTH);
  assign cur_bit   = byte_r[bit_r];
  // A non-positive tree entry gives the symbol index as its magnitude.
  assign mag       = BYTE_W'(0) - raw;
  assign tbl_raddr = ctl.tree_rd ? (ADDR_W'(node_r) + ADDR_W'(cur_bit))
                                 : (ADDR_W'(offset_r) + ADDR_W'(mag));

  hfu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (in_byte),
    .re    (ctl.tree_rd || ctl.sym_rd),
    .raddr (tbl_raddr),
    .rdata (raw)
  );

  // Status toward the controller.
  assign sts.words_zero = (words_left_r == '0);
  assign sts.is_node    = (raw != '0) && !raw[BYTE_W-1];
  assign sts.bit_last   = (bit_r == '1);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.last_emit  = (words_left_r == COUNT_W'(1));

  // Configuration, offset shadow and word counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= '0;
      words_left_r <= '0;
      offset_r     <= '0;
    end else begin
      if (cfg_we) begin
        word_count_r <= cfg_data;
      end
      if (tbl_we && (in_addr == '0)) begin
        offset_r <= in_byte;
      end
      if (ctl.start) begin
        words_left_r <= word_count_r;
      end else if (ctl.emit) begin
        words_left_r <= words_left_r - COUNT_W'(1);
      end
    end
  end

  // Walk node and bit pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= ROOT_NODE;
      bit_r  <= '0;
    end else begin
      if (ctl.start || ctl.emit) begin
        node_r <= ROOT_NODE;
      end else if (ctl.step_node) begin
        node_r <= raw[NODE_W-1:0];
      end
      if (ctl.load_byte) begin
        bit_r <= '0;
      end else if (ctl.next_bit) begin
        bit_r <= bit_r + BITIDX_W'(1);
      end
    end
  end

  // Bitstream byte under decode.
  always_ff @(posedge clk) begin
    if (ctl.load_byte) begin
      byte_r <= in_byte;
    end
  end

  // Output register: holds a word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_word_r <= expand_symbol(raw);
      out_last_r <= sts.last_emit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

  // A word is only emitted when the output register has room.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (!out_valid_r || out_ready))
    else $error("word emitted into a full output register");

  // Each emitted word takes exactly one off the counter.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> (words_left_r == $past(words_left_r) - COUNT_W'(1)))
    else $error("word counter did not step by one");

  // No word is produced once the count is used up.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> !sts.words_zero)
    else $error("word emitted with no words left");

endmodule

FILE: rtl/huffman_font_unpacker.sv
// ----------------------------------------------------------------------------
// huffman_font_unpacker: table-driven Huffman decoder to 4-bit pixel words
// Input items (in_*) carry a kind on in_tuser: table byte write, start of a
// decode, or a bitstream byte. The cfg_* channel sets the word count that a
// start command loads; it is always ready. Results (out_*) carry one word of
// eight pixels on out_tdata and mark the final word of the count on out_tlast.
// Table writes and start commands complete as they are taken. A bitstream byte
// walks the tree one bit at a time through the single read port of the table
// store: an inner-node step is a tree read and its evaluation, a leaf adds a
// symbol read, and the byte holds the input until its walk ends, early once
// the count runs out, including any wait on a stalled receiver. The first word
// reaches the output register through the tree read, its evaluation and the
// symbol read of its leaf bit. The next item is taken in the cycle after the
// walk of a byte ends. When the receiver stalls, the decode holds at the next
// finished symbol until the output register frees. After reset the word count
// and words left are zero, the walk is at its root node, the output is empty,
// and the table store holds nothing defined until it is written.
// ----------------------------------------------------------------------------
module huffman_font_unpacker
  import hfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [8:0] table_addr, [16:9] data_byte, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] pixel_word
  output logic        out_tlast,  // last_word
  // Configuration.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // word_count
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // Controller.
  hfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (cmd_code_t'(in_tuser)),
    .in_ready (in_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Datapath.
  hfu_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_addr   (in_tdata[TADDR_W-1:0]),
    .in_byte   (in_tdata[TADDR_W +: BYTE_W]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

FILE: tb/huffman_font_unpacker_checker.sv
// ----------------------------------------------------------------------------
// huffman_font_unpacker_checker: pixel word prediction and comparison
// Watches the input, configuration and result channels of the unpacker. It
// keeps its own copy of the code table, the walk position, the word count
// and the words left. For every accepted bitstream byte it walks the tree and
// queues the pixel words that byte must produce. Every accepted result is
// compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module huffman_font_unpacker_checker
  import hfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          words_pending,
  output int          words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] WALK_ROOT = 8'(ROOT_NODE);

  typedef struct packed {
    logic [31:0] pixels;
    logic        last;
  } pixel_word_t;

  // Local copy of the table store and of the decoder state.
  logic [7:0]  code_mem [TABLE_DEPTH];
  logic [7:0]  walk_node;
  logic [15:0] words_left;
  logic [15:0] word_count_reg;
  pixel_word_t expected_words [$];
  int          fails = 0;
  int          checked = 0;

  initial begin
    fail_count    = 0;
    words_pending = 0;
    words_checked = 0;
  end

  // Reads above the store answer zero.
  function automatic logic [7:0] code_at(int unsigned addr);
    if (addr >= TABLE_DEPTH) return 8'h00;
    return code_mem[addr];
  endfunction

  // Each 2-bit pair of a symbol becomes one byte of two pixel nibbles.
  function automatic logic [31:0] pixels_of(logic [7:0] sym);
    logic [31:0] word;
    word = '0;
    for (int k = 0; k < 4; k++) begin
      case (sym[2*k +: 2])
        2'd0: word[8*k +: 8] = 8'h00;
        2'd1: word[8*k +: 8] = 8'h01;
        2'd2: word[8*k +: 8] = 8'h10;
        default: word[8*k +: 8] = 8'h11;
      endcase
    end
    return word;
  endfunction

  // Walk the tree over one bitstream byte, lowest bit first, and queue the
  // words that its leaves produce until the count runs out.
  task automatic decode_bitstream_byte(logic [7:0] bits);
    logic [7:0]  raw;
    logic [8:0]  mag;
    logic [7:0]  sym;
    pixel_word_t word;
    for (int b = 0; b < 8 && words_left != 0; b++) begin
      raw = code_at(int'(walk_node) + int'(bits[b]));
      if (raw != 8'h00 && raw < 8'h80) begin
        walk_node = raw;
      end else begin
        // A zero or negative entry is a leaf: its magnitude picks the symbol.
        mag = (raw == 8'h00) ? 9'd0 : 9'h100 - 9'(raw);
        sym = code_at(int'(code_at(0)) + int'(mag));
        words_left = words_left - 16'd1;
        word.pixels = pixels_of(sym);
        word.last = (words_left == 16'd0);
        expected_words.push_back(word);
        walk_node = WALK_ROOT;
      end
    end
    if (words_left == 16'd0) walk_node = WALK_ROOT;
  endtask

  always @(posedge clk) begin : watch
    pixel_word_t want;
    if (!rst_n) begin
      walk_node = WALK_ROOT;
      words_left = '0;
      word_count_reg = '0;
      expected_words.delete();
    end else begin
      // Results first: a word leaving now never belongs to an item taken now.
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          fails++;
          $display("%0t: unexpected pixel word %h last %b", $time, out_tdata, out_tlast);
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (out_tdata !== want.pixels) begin
            fails++;
            $display("%0t: pixel_word expected %h actual %h", $time, want.pixels, out_tdata);
          end
          if (out_tlast !== want.last) begin
            fails++;
            $display("%0t: last_word expected %b actual %b", $time, want.last, out_tlast);
          end
        end
      end
      if (cfg_valid && cfg_ready) word_count_reg = cfg_data;
      if (in_tvalid && in_tready) begin
        case (cmd_code_t'(in_tuser))
          CMD_TABLE: begin
            if (int'(in_tdata[8:0]) < TABLE_DEPTH) code_mem[in_tdata[8:0]] = in_tdata[16:9];
          end
          CMD_START: begin
            words_left = word_count_reg;
            walk_node = WALK_ROOT;
          end
          CMD_BITS: decode_bitstream_byte(in_tdata[16:9]);
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    words_pending <= expected_words.size();
    words_checked <= checked;
  end

endmodule

FILE: tb/huffman_font_unpacker_tb.sv
// ----------------------------------------------------------------------------
// huffman_font_unpacker_tb: stimulus and verdict for the Huffman font unpacker
// Loads well-formed code tables, sets word counts and streams bitstream
// bytes with random content, mixed with ignored commands, table rewrites in
// the middle of a decode and stray starts. Both channels idle at random; the
// checker beside the block predicts and compares every pixel word.
// ----------------------------------------------------------------------------
module huffman_font_unpacker_tb
  import hfu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // A walk reads at most offset 255 plus magnitude 128, so writes from here
  // up are never read back.
  localparam int       SPARE_LO     = 384;
  localparam int       SETTLE       = 40;
  localparam int       HOLD_AT_WORD = 40;
  localparam int       HOLD_CYCLES  = 300;
  localparam int       IDLE_LIMIT   = 3000;
  localparam int       ITEM_TARGET  = 200;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = CMD_NONE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  int fails;
  int pending;
  int words_checked;

  int tx_quiet = 0;
  int rx_quiet = 0;
  int rx_wait = 0;
  int rx_words = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int phase_no = 0;

  // Shape of the current code table.
  int node_span = 1;
  int max_mag = 0;
  int sym_base = 20;

  huffman_font_unpacker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  huffman_font_unpacker_checker words_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fails),
    .words_pending (pending),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle cycles before an item; now and then a stretch with no idling.
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(6, 30);
    return $urandom_range(0, 18);
  endfunction

  // Receiver: random stalls after each word, and one long hold-off so that
  // the block fills up and stops taking input.
  always @(posedge clk) begin : sink
    int gap;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
    end else if (out_tvalid && out_tready) begin
      rx_words <= rx_words + 1;
      if (rx_words == HOLD_AT_WORD) gap = HOLD_CYCLES;
      else gap = draw_gap(rx_quiet);
      out_tready <= (gap == 0);
      rx_wait <= gap;
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else begin
      out_tready <= 1'b1;
      rx_wait <= 0;
    end
  end

  // Watchdog: ends the run when no item moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one item after a random gap and wait until it is taken. The valid
  // stays high on return, so the caller either sends again or lowers it.
  task automatic send_item(cmd_code_t cmd, logic [8:0] addr, logic [7:0] data);
    int gap;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {7'b0, data, addr};
    do @(posedge clk); while (!in_tready);
    if (cmd != CMD_NONE) items_sent++;
  endtask

  // Stop offering, wait for every predicted word, then let the walk finish.
  // The pending count from the checker is registered, so let it update first.
  task automatic drain_words();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_word_count(logic [15:0] count);
    drain_words();
    cfg_valid <= 1'b1;
    cfg_data <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A child entry: a pointer to one of the inner nodes, or a leaf.
  function automatic logic [7:0] random_child();
    int mag;
    if ($urandom_range(0, 2) == 0) return 8'(2 + 2 * $urandom_range(0, node_span - 1));
    mag = $urandom_range(0, max_mag);
    return (mag == 0) ? 8'h00 : 8'(256 - mag);
  endfunction

  // Write a fresh header, tree and symbol table in which every entry that a
  // walk can reach is written.
  task automatic load_code_tables();
    node_span = $urandom_range(1, 6);
    max_mag = $urandom_range(0, 7);
    sym_base = $urandom_range(20, 255);
    send_item(CMD_TABLE, 9'd0, 8'(sym_base));
    for (int a = 2; a < 2 + 2 * node_span; a++) send_item(CMD_TABLE, 9'(a), random_child());
    for (int m = 0; m <= max_mag; m++) send_item(CMD_TABLE, 9'(sym_base + m), 8'($urandom));
  endtask

  // One decode: a word count, maybe new tables, a start and a run of bytes
  // with occasional noise in between.
  task automatic run_phase();
    logic [15:0] count;
    int n_bytes;
    if (phase_no == 2) count = 16'hFFFF;
    else if (phase_no == 4) count = 16'($urandom_range(0, 65535));
    else if ($urandom_range(0, 7) == 0) count = 16'd0;
    else count = 16'($urandom_range(1, 40));
    set_word_count(count);
    if (phase_no == 0 || $urandom_range(0, 3) != 0) load_code_tables();
    send_item(CMD_START, 9'($urandom), 8'($urandom));
    n_bytes = $urandom_range(2, 10);
    repeat (n_bytes) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 4))
          0: send_item(CMD_NONE, 9'($urandom), 8'($urandom));
          1: send_item(CMD_TABLE, 9'($urandom_range(SPARE_LO, TABLE_DEPTH - 1)), 8'($urandom));
          2: send_item(CMD_TABLE, 9'(sym_base + $urandom_range(0, max_mag)), 8'($urandom));
          3: send_item(CMD_TABLE, 9'(2 + $urandom_range(0, 2 * node_span - 1)),
                       random_child());
          default: send_item(CMD_START, 9'($urandom), 8'($urandom));
        endcase
      end
      send_item(CMD_BITS, 9'($urandom), 8'($urandom));
    end
    phase_no++;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nothing decodes before a start; the unused command and a write to the
    // top address change nothing that is read.
    send_item(CMD_BITS, 9'h000, 8'hA5);
    send_item(CMD_NONE, 9'h1FF, 8'hFF);
    send_item(CMD_TABLE, 9'h1FF, 8'hFF);

    // Offset 255; root goes to node 4 on a zero bit and to the most negative
    // leaf on a one bit; node 4 holds a zero leaf and a leaf of magnitude 1.
    set_word_count(16'd0);
    send_item(CMD_TABLE, 9'd0, 8'hFF);
    send_item(CMD_TABLE, 9'd2, 8'h04);
    send_item(CMD_TABLE, 9'd3, 8'h80);
    send_item(CMD_TABLE, 9'd4, 8'h00);
    send_item(CMD_TABLE, 9'd5, 8'hFF);
    send_item(CMD_TABLE, 9'd255, 8'hE4);
    send_item(CMD_TABLE, 9'd256, 8'hFF);
    send_item(CMD_TABLE, 9'd383, 8'h00);

    // A zero count makes the bitstream bytes dead.
    send_item(CMD_START, 9'h000, 8'h00);
    send_item(CMD_BITS, 9'h000, 8'h5A);

    // The count runs out inside the second byte; the third is dropped.
    set_word_count(16'd5);
    send_item(CMD_START, 9'h000, 8'h00);
    send_item(CMD_BITS, 9'h000, 8'h00);
    send_item(CMD_BITS, 9'h000, 8'hFF);
    send_item(CMD_BITS, 9'h000, 8'h33);

    // A symbol rewritten mid-decode, then a byte of eight leaves.
    set_word_count(16'd12);
    send_item(CMD_START, 9'h000, 8'h00);
    send_item(CMD_BITS, 9'h000, 8'h00);
    send_item(CMD_TABLE, 9'd383, 8'h1B);
    send_item(CMD_BITS, 9'h000, 8'hFF);

    while (items_sent < ITEM_TARGET) run_phase();
    drain_words();

    $display("Run covered %0d input items over %0d random decodes, word counts 0 to 65535.",
             items_sent, phase_no);
    $display("%0d pixel words were checked against the prediction.", words_checked);
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
